FILE: design/trdf_pkg.sv
// Shared widths, types and limits of the trial-division factorizer.
package trdf_pkg;

    localparam int NUMBER_WIDTH  = 32;
    localparam int VALUE_WIDTH   = 31;
    localparam int FACTOR_WIDTH  = 31;
    localparam int DIV_WIDTH     = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH      = 2 * DIV_WIDTH;
    localparam int MAX_RESULTS   = 30;
    localparam int COUNT_WIDTH   = $clog2(MAX_RESULTS);
    localparam int STEP_WIDTH    = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [DIV_WIDTH-1:0]   divisor_t;

    // One classified request handed from the front to the back
    typedef struct packed {
        value_t value;
        logic   empty;
    } job_t;

    // One result on its way to the output queue
    typedef struct packed {
        logic [FACTOR_WIDTH-1:0] factor;
        logic                    last;
        logic                    empty_res;
    } res_t;

endpackage

FILE: design/trdf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module trdf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [trdf_pkg::NUMBER_WIDTH-1:0] number,
    input  logic                              push,
    output logic                              full,
    output trdf_pkg::job_t                    job,
    output logic                              job_valid,
    input  logic                              job_take
);
    import trdf_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    value_t     value_w;
    logic       empty_w;
    logic       do_push, do_pop;

    // Classification: negative, zero and one have no factors
    assign value_w = number[VALUE_WIDTH-1:0];
    assign empty_w = number[NUMBER_WIDTH-1] || (value_w <= value_t'(1));

    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= '{value: value_w, empty: empty_w};
        end
    end

endmodule

FILE: design/trdf_div.sv
// Restoring divider, one quotient bit per cycle.
module trdf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  trdf_pkg::value_t   dividend,
    input  trdf_pkg::divisor_t divisor,
    output logic               busy,
    output logic               done,
    output trdf_pkg::value_t   quotient,
    output trdf_pkg::divisor_t remainder
);
    import trdf_pkg::*;

    value_t                quo_reg, quo_next;
    divisor_t              rem_reg, rem_next;
    divisor_t              dvs_reg, dvs_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_WIDTH:0]    trial;
    logic                  ge;

    // One shift-subtract step
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_WIDTH'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next  = ge ? DIV_WIDTH'(trial - {1'b0, dvs_reg}) : trial[DIV_WIDTH-1:0];
            step_next = step_reg - STEP_WIDTH'(1);
            if (step_reg == STEP_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/trdf_outq.sv
// Two-entry result queue that drives the result ports.
module trdf_outq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  trdf_pkg::res_t                    din,
    input  logic                              wr,
    output logic                              wr_full,
    input  logic                              pop,
    output logic                              empty,
    output logic [trdf_pkg::FACTOR_WIDTH-1:0] factor,
    output logic                              last,
    output logic                              empty_res
);
    import trdf_pkg::*;

    res_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;
    res_t       head;

    assign wr_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr && !wr_full;
    assign do_rd   = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    assign factor    = head.factor;
    assign last      = head.last;
    assign empty_res = head.empty_res;

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ do_wr;
            rd_ptr_reg <= rd_ptr_reg ^ do_rd;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: design/trdf_back.sv
// Back end: trial-division engine that turns a queued request into results.
module trdf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  trdf_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_take,
    output trdf_pkg::res_t res,
    output logic           res_push,
    input  logic           res_full
);
    import trdf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FOUND = 7'b0010000,
        S_FLUSH = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    value_t                 v_reg, v_next;
    divisor_t               d_reg, d_next;
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;
    value_t                 pend_reg, pend_next;
    logic                   have_pend_reg, have_pend_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   flush_last_reg, flush_last_next;
    value_t                 fin_factor_reg, fin_factor_next;
    logic                   fin_empty_reg, fin_empty_next;

    logic     div_start, div_busy, div_done;
    value_t   div_dividend, div_quo;
    divisor_t div_rem;

    trdf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (d_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        pend_next       = pend_reg;
        have_pend_next  = have_pend_reg;
        count_next      = count_reg;
        flush_last_next = flush_last_reg;
        fin_factor_next = fin_factor_reg;
        fin_empty_next  = fin_empty_reg;
        job_take        = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        div_start       = 1'b0;
        div_dividend    = v_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    if (job.empty)
                    begin
                        fin_factor_next = '0;
                        fin_empty_next  = 1'b1;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        v_next         = job.value;
                        d_next         = DIV_WIDTH'(2);
                        have_pend_next = 1'b0;
                        count_next     = '0;
                        state_next     = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                sq_next    = SQ_WIDTH'(d_reg) * SQ_WIDTH'(d_reg);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sq_reg <= SQ_WIDTH'(v_reg))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (v_reg > value_t'(1))
                begin
                    // Remainder above one is the final prime
                    fin_factor_next = v_reg;
                    fin_empty_next  = 1'b0;
                    flush_last_next = 1'b0;
                    state_next      = S_FLUSH;
                end
                else
                begin
                    // Last divisor brought the value to one
                    flush_last_next = 1'b1;
                    state_next      = S_FLUSH;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        if (count_reg >= COUNT_WIDTH'(MAX_RESULTS - 1))
                        begin
                            // Result limit: this factor closes the list
                            fin_factor_next = VALUE_WIDTH'(d_reg);
                            fin_empty_next  = 1'b0;
                            flush_last_next = 1'b0;
                            state_next      = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_FOUND;
                        end
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_WIDTH'(1);
                        state_next = S_SQ;
                    end
                end
            end
            S_FOUND:
            begin
                if (!have_pend_reg || !res_full)
                begin
                    res_push       = have_pend_reg;
                    res            = '{factor: FACTOR_WIDTH'(pend_reg), last: 1'b0,
                                       empty_res: 1'b0};
                    pend_next      = VALUE_WIDTH'(d_reg);
                    have_pend_next = 1'b1;
                    count_next     = count_reg + COUNT_WIDTH'(1);
                    v_next         = div_quo;
                    div_dividend   = div_quo;
                    div_start      = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_FLUSH:
            begin
                if (!have_pend_reg || !res_full)
                begin
                    res_push   = have_pend_reg;
                    res        = '{factor: FACTOR_WIDTH'(pend_reg), last: flush_last_reg,
                                   empty_res: 1'b0};
                    state_next = flush_last_reg ? S_IDLE : S_FIN;
                end
            end
            S_FIN:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res        = '{factor: FACTOR_WIDTH'(fin_factor_reg), last: 1'b1,
                                   empty_res: fin_empty_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_pend_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg          <= v_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        pend_reg       <= pend_next;
        flush_last_reg <= flush_last_next;
        fin_factor_reg <= fin_factor_next;
        fin_empty_reg  <= fin_empty_next;
    end

`ifndef SYNTH
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_close_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && flush_last_reg) |-> have_pend_reg)
        else $error("closing a list with no held factor");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOUND) |-> (count_reg < COUNT_WIDTH'(MAX_RESULTS - 1)))
        else $error("factor count past the result limit");
`endif

endmodule

FILE: design/trial_division_factorizer.sv
// Top level of the trial-division prime factorizer.
// Each request carries a signed 32-bit number; the block returns its prime factors in
// nondecreasing order, one result per factor, with last set on the final one. Zero, one
// and negative numbers give a single result with factor 0, last 1 and empty_res 1.
// The front end queues up to two classified requests; the back end tries divisors from
// 2 upward with a bit-serial divider, squaring and comparing each divisor before the
// divide and result handoff. A 31-bit prime needs about 46341 divisors tried. Results
// wait in a two-entry queue, so the engine keeps working while the consumer stalls,
// until that queue is full and a factor is waiting to be written.
module trial_division_factorizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [trdf_pkg::NUMBER_WIDTH-1:0] number,
    input  logic                              push,
    output logic                              full,
    output logic [trdf_pkg::FACTOR_WIDTH-1:0] factor,
    output logic                              last,
    output logic                              empty_res,
    output logic                              empty,
    input  logic                              pop
);
    import trdf_pkg::*;

    job_t job;
    logic job_valid, job_take;
    res_t res;
    logic res_push, res_full;

    trdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .push      (push),
        .full      (full),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    trdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    trdf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (res),
        .wr        (res_push),
        .wr_full   (res_full),
        .pop       (pop),
        .empty     (empty),
        .factor    (factor),
        .last      (last),
        .empty_res (empty_res)
    );

endmodule
